// ===== design/sfp_pkg.sv =====
`timescale 1ns / 1ps

package sfp_pkg;

    // Largest number of data bytes in one frame; the store depth follows from it.
    localparam int MAX_DATA = 8;
    localparam int IDX_W    = $clog2(MAX_DATA);
    localparam int LEN_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_DATA     = 3'd1,
        EV_BAD_TYPE = 3'd2,
        EV_BAD_LEN  = 3'd3,
        EV_BAD_SUM  = 3'd4
    } event_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MAX   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd3;

    // One command from the parser to the emitter: an error or a whole good frame.
    typedef struct packed {
        event_t                     ev;
        logic [7:0]                 frame_type;
        logic [LEN_W-1:0]           frame_length;
        logic [MAX_DATA-1:0][7:0]   data;
    } cmd_t;

    // Queue status seen by the parser and the emitter.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/serial_frame_parser_checksum_top.sv =====
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_ready     rx_byte
// output    out_valid / out_ready   event_res, frame_type, frame_length,
//                                   byte_value, byte_index, last
// config    cfg_we                  cfg_index, cfg_wdata
//
// The parser takes one byte per cycle while the command queue has room.
// The emitter loads a command from the queue, then gives one result per
// cycle while the output is free: one for an error, N for a good frame of N data bytes.
// in_ready drops only while the command queue is full.
// Reset returns the parser to hunting and restores the register defaults.

module serial_frame_parser_checksum_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    event_res,
    output logic [7:0]                    frame_type,
    output logic [sfp_pkg::LEN_W-1:0]     frame_length,
    output logic [7:0]                    byte_value,
    output logic [sfp_pkg::IDX_W-1:0]     byte_index,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_wdata
);
    import sfp_pkg::*;

    q_status_t q_status;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      pop_cmd;

    // Front: byte parser and checker.
    sfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Command queue between parser and emitter.
    sfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    // Back: result emitter.
    sfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop          (pop),
        .pop_cmd      (pop_cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .frame_type   (frame_type),
        .frame_length (frame_length),
        .byte_value   (byte_value),
        .byte_index   (byte_index),
        .last         (last)
    );

`ifndef SYNTHESIS
    // A shown result always carries a real event.
    a_event_real: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res != EV_NONE)
        else $error("result without an event");

    // Error results stand alone and end their run.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != EV_DATA) |-> last)
        else $error("error result without last mark");

    // A data result is marked last exactly at the final byte of its frame.
    a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_DATA)
        |-> (last == ({1'b0, byte_index} + LEN_W'(1) == frame_length)))
        else $error("last mark does not match frame length");

    // The input side stalls only when the command queue is full.
    a_ready_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_status.full)
        else $error("input stalled with room in the queue");
`endif

endmodule

// ===== design/sfp_front.sv =====
`timescale 1ns / 1ps

module sfp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    input  logic                          cfg_we,
    input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_wdata,
    input  sfp_pkg::q_status_t            q_status,
    output logic                          push,
    output sfp_pkg::cmd_t                 push_cmd
);
    import sfp_pkg::*;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_TYPE  = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_CHECK = 5'b10000
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [7:0]               held_type_reg, held_type_next;
    logic [LEN_W-1:0]         held_length_reg, held_length_next;
    logic [LEN_W-1:0]         data_count_reg, data_count_next;
    logic [7:0]               running_sum_reg, running_sum_next;
    logic [MAX_DATA-1:0][7:0] store_reg;

    logic [7:0]       sync_byte_reg;
    logic [7:0]       type_min_reg;
    logic [7:0]       type_max_reg;
    logic [LEN_W-1:0] max_length_reg;

    logic             accept;
    logic             store_we;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] count_inc;

    // A byte is taken only when the queue has room for whatever it may cause.
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Effective length limit is the smaller of the register and the store depth.
    assign limit     = (max_length_reg > LEN_W'(MAX_DATA)) ? LEN_W'(MAX_DATA) : max_length_reg;
    assign count_inc = data_count_reg + LEN_W'(1);

    // Frame parser: classifies each byte and issues commands to the queue.
    always_comb
    begin
        phase_next       = phase_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        data_count_next  = data_count_reg;
        running_sum_next = running_sum_reg;
        store_we         = 1'b0;
        push             = 1'b0;
        push_cmd         = '0;
        push_cmd.ev      = EV_NONE;
        if (accept)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    if (rx_byte < type_min_reg || rx_byte > type_max_reg)
                    begin
                        phase_next  = PH_HUNT;
                        push        = 1'b1;
                        push_cmd.ev = EV_BAD_TYPE;
                    end
                    else
                    begin
                        held_type_next   = rx_byte;
                        running_sum_next = rx_byte;
                        phase_next       = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (rx_byte == 8'd0 || rx_byte > {{(8-LEN_W){1'b0}}, limit})
                    begin
                        phase_next  = PH_HUNT;
                        push        = 1'b1;
                        push_cmd.ev = EV_BAD_LEN;
                    end
                    else
                    begin
                        held_length_next = rx_byte[LEN_W-1:0];
                        running_sum_next = running_sum_reg + rx_byte;
                        data_count_next  = '0;
                        phase_next       = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    store_we         = 1'b1;
                    running_sum_next = running_sum_reg + rx_byte;
                    if (count_inc >= held_length_reg)
                    begin
                        data_count_next = '0;
                        phase_next      = PH_CHECK;
                    end
                    else
                    begin
                        data_count_next = count_inc;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT;
                    push       = 1'b1;
                    if (rx_byte == ~running_sum_reg)
                    begin
                        push_cmd.ev           = EV_DATA;
                        push_cmd.frame_type   = held_type_reg;
                        push_cmd.frame_length = held_length_reg;
                        push_cmd.data         = store_reg;
                    end
                    else
                    begin
                        push_cmd.ev = EV_BAD_SUM;
                    end
                end
                PH_HUNT:
                begin
                    if (rx_byte == sync_byte_reg)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            held_type_reg   <= '0;
            held_length_reg <= '0;
            data_count_reg  <= '0;
            running_sum_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            data_count_reg  <= data_count_next;
            running_sum_reg <= running_sum_next;
        end
    end

    // Data byte store; entries are read only after this frame has written them.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[data_count_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg  <= 8'd0;
            type_min_reg   <= 8'd0;
            type_max_reg   <= 8'd255;
            max_length_reg <= LEN_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_BYTE:  sync_byte_reg  <= cfg_wdata;
                CFG_TYPE_MIN:   type_min_reg   <= cfg_wdata;
                CFG_TYPE_MAX:   type_max_reg   <= cfg_wdata;
                CFG_MAX_LENGTH: max_length_reg <= cfg_wdata[LEN_W-1:0];
                default:        sync_byte_reg  <= sync_byte_reg;
            endcase
        end
    end

endmodule

// ===== design/sfp_queue.sv =====
`timescale 1ns / 1ps

module sfp_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sfp_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output sfp_pkg::cmd_t      pop_cmd,
    output sfp_pkg::q_status_t q_status
);
    import sfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_cmd        = entry_reg[rd_ptr_reg];

    // Pointer and fill count update, with wrap at the last entry.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/sfp_back.sv =====
`timescale 1ns / 1ps

module sfp_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sfp_pkg::q_status_t        q_status,
    output logic                      pop,
    input  sfp_pkg::cmd_t             pop_cmd,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0]                event_res,
    output logic [7:0]                frame_type,
    output logic [sfp_pkg::LEN_W-1:0] frame_length,
    output logic [7:0]                byte_value,
    output logic [sfp_pkg::IDX_W-1:0] byte_index,
    output logic                      last
);
    import sfp_pkg::*;

    cmd_t             cmd_reg;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             out_valid_reg, out_valid_next;
    event_t           event_reg, event_next;
    logic [7:0]       type_reg, type_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [7:0]       value_reg, value_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic             last_reg, last_next;

    logic             slot_free;
    logic             is_final;

    assign out_valid    = out_valid_reg;
    assign event_res    = event_reg;
    assign frame_type   = type_reg;
    assign frame_length = length_reg;
    assign byte_value   = value_reg;
    assign byte_index   = index_reg;
    assign last         = last_reg;

    // The output register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = !busy_reg && !q_status.empty;
    assign is_final  = (cmd_reg.ev != EV_DATA)
                       || ({1'b0, idx_reg} + LEN_W'(1) == cmd_reg.frame_length);

    // Emitter: steps through the current command, one result per cycle while the output register is free.
    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        event_next     = event_reg;
        type_next      = type_reg;
        length_next    = length_reg;
        value_next     = value_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg && slot_free)
        begin
            out_valid_next = 1'b1;
            event_next     = cmd_reg.ev;
            type_next      = cmd_reg.frame_type;
            length_next    = cmd_reg.frame_length;
            value_next     = (cmd_reg.ev == EV_DATA) ? cmd_reg.data[idx_reg] : 8'd0;
            index_next     = (cmd_reg.ev == EV_DATA) ? idx_reg : '0;
            last_next      = is_final;
            if (is_final)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= pop_cmd;
        end
        event_reg  <= event_next;
        type_reg   <= type_next;
        length_reg <= length_next;
        value_reg  <= value_next;
        index_reg  <= index_next;
        last_reg   <= last_next;
    end

endmodule
